// ===== src/mda_pkg.sv =====
// Shared types, constants and the decimal digit split for the 4D address matcher.
// Used by the register block, the component matcher and the top level.
package mda_pkg;

    localparam int NUM_W    = 16;
    localparam int PAT_W    = 40;
    localparam int CHAR_W   = 4;
    localparam int DIGITS   = 5;
    localparam int CNT_W    = 3;
    localparam int TYPE_W   = 3;
    localparam int ADDR_W   = 6;
    localparam int DATA_W   = 64;

    localparam logic [CHAR_W-1:0] CODE_STAR  = 4'd10;
    localparam logic [CHAR_W-1:0] CODE_QUEST = 4'd11;
    localparam logic [CHAR_W-1:0] CODE_DIGIT_MAX = 4'd9;

    localparam logic [TYPE_W-1:0] TYPE_FULL   = 3'd0;
    localparam logic [TYPE_W-1:0] TYPE_ZONE   = 3'd1;
    localparam logic [TYPE_W-1:0] TYPE_REGION = 3'd2;
    localparam logic [TYPE_W-1:0] TYPE_NET    = 3'd3;
    localparam logic [TYPE_W-1:0] TYPE_HUB    = 3'd4;
    localparam logic [TYPE_W-1:0] TYPE_NODE   = 3'd5;

    localparam logic [2:0] REG_TYPE  = 3'd0;
    localparam logic [2:0] REG_ZONE  = 3'd1;
    localparam logic [2:0] REG_NET   = 3'd2;
    localparam logic [2:0] REG_NODE  = 3'd3;
    localparam logic [2:0] REG_POINT = 3'd4;

    localparam logic [16:0] POW10 [DIGITS] = '{17'd1, 17'd10, 17'd100, 17'd1000, 17'd10000};

    typedef struct packed {
        logic [TYPE_W-1:0] ptype;
        logic [PAT_W-1:0]  zone;
        logic [PAT_W-1:0]  net;
        logic [PAT_W-1:0]  node;
        logic [PAT_W-1:0]  point;
    } t_cfg;

    // Decimal text of a number: digits left aligned, most significant first.
    typedef struct packed {
        logic [CNT_W-1:0]               count;
        logic [DIGITS-1:0][CHAR_W-1:0]  dig;
    } t_dec;

    function automatic t_dec num_to_dec(input logic [NUM_W-1:0] num);
        t_dec                           res;
        logic [DIGITS-1:0][CHAR_W-1:0]  place;
        logic [NUM_W-1:0]               rem;
        logic [16:0]                    thr;
        logic [16:0]                    sub;
        logic [CHAR_W-1:0]              q;
        int                             k;
        int                             j;
        int                             i;
        rem   = num;
        place = '0;
        // one compare bank per decimal place above the units, most significant first
        for (k = DIGITS - 1; k >= 1; k--) begin
            q   = '0;
            sub = '0;
            for (j = 1; j <= 9; j++) begin
                thr = 17'(j) * POW10[k];
                if ({1'b0, rem} >= thr) begin
                    q   = 4'(j);
                    sub = thr;
                end
            end
            place[k] = q;
            rem      = rem - sub[NUM_W-1:0];
        end
        place[0] = rem[CHAR_W-1:0];

        if (num >= 16'd10000)     res.count = 3'd5;
        else if (num >= 16'd1000) res.count = 3'd4;
        else if (num >= 16'd100)  res.count = 3'd3;
        else if (num >= 16'd10)   res.count = 3'd2;
        else                      res.count = 3'd1;

        res.dig = '0;
        for (i = 0; i < DIGITS; i++) begin
            for (k = 0; k < DIGITS; k++) begin
                if (4'(i) + 4'(k) + 4'd1 == {1'b0, res.count}) begin
                    res.dig[i] = place[k];
                end
            end
        end
        return res;
    endfunction

endpackage

// ===== src/match_4d_address_pattern_top.sv =====
// Path: an accepted item is held in the input register and then in the result
// register, which drives o_valid; a stalled result holds it in the input register.
// Throughput: one item per cycle; the four component compares sit between the
// input register and the result register. A stalled result blocks intake once
// the input register also holds an item.
// Reset (synchronous, active low) empties both stages and clears all config.
module match_4d_address_pattern_top #(
    parameter int PATTERN_CHARS = 9
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [mda_pkg::NUM_W-1:0]    i_address_zone,
    input  logic [mda_pkg::NUM_W-1:0]    i_address_net,
    input  logic [mda_pkg::NUM_W-1:0]    i_address_node,
    input  logic [mda_pkg::NUM_W-1:0]    i_address_point,
    input  logic                         i_nodelist_open,
    input  logic                         i_region_known,
    input  logic [mda_pkg::NUM_W-1:0]    i_region_number,
    input  logic                         i_hub_known,
    input  logic [mda_pkg::NUM_W-1:0]    i_hub_number,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic                         o_is_match,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [mda_pkg::ADDR_W-1:0]   paddr,
    input  logic [mda_pkg::DATA_W-1:0]   pwdata,
    output logic [mda_pkg::DATA_W-1:0]   prdata,
    output logic                         pready
);
    import mda_pkg::*;

    t_cfg             cfg;
    logic             r_in_valid;
    logic [NUM_W-1:0] r_zone;
    logic [NUM_W-1:0] r_net;
    logic [NUM_W-1:0] r_node;
    logic [NUM_W-1:0] r_point;
    logic             r_nl_open;
    logic             r_region_known;
    logic [NUM_W-1:0] r_region;
    logic             r_hub_known;
    logic [NUM_W-1:0] r_hub;
    logic             r_out_valid;
    logic             r_match;
    logic             n_match;
    logic             out_adv;
    logic             in_adv;
    logic [NUM_W-1:0] net_num;
    logic [NUM_W-1:0] node_num;
    logic             zone_m;
    logic             net_m;
    logic             node_m;
    logic             point_m;
    logic             zone_ok;

    mda_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    assign out_adv = !r_out_valid || !i_stall;
    assign in_adv  = !r_in_valid || out_adv;
    assign o_stall = !in_adv;
    assign o_valid    = r_out_valid;
    assign o_is_match = r_match;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_adv) begin
                r_in_valid <= i_valid;
            end
            if (out_adv) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_adv && i_valid) begin
            r_zone         <= i_address_zone;
            r_net          <= i_address_net;
            r_node         <= i_address_node;
            r_point        <= i_address_point;
            r_nl_open      <= i_nodelist_open;
            r_region_known <= i_region_known;
            r_region       <= i_region_number;
            r_hub_known    <= i_hub_known;
            r_hub          <= i_hub_number;
        end
        if (out_adv && r_in_valid) begin
            r_match <= n_match;
        end
    end

    // region mode tests the net pattern on the region, hub mode the node pattern on the hub
    assign net_num  = (cfg.ptype == TYPE_REGION) ? r_region : r_net;
    assign node_num = (cfg.ptype == TYPE_HUB) ? r_hub : r_node;

    mda_comp_match #(.PATTERN_CHARS(PATTERN_CHARS)) u_zone_m (
        .i_pattern (cfg.zone),
        .i_num     (r_zone),
        .o_match   (zone_m)
    );

    mda_comp_match #(.PATTERN_CHARS(PATTERN_CHARS)) u_net_m (
        .i_pattern (cfg.net),
        .i_num     (net_num),
        .o_match   (net_m)
    );

    mda_comp_match #(.PATTERN_CHARS(PATTERN_CHARS)) u_node_m (
        .i_pattern (cfg.node),
        .i_num     (node_num),
        .o_match   (node_m)
    );

    mda_comp_match #(.PATTERN_CHARS(PATTERN_CHARS)) u_point_m (
        .i_pattern (cfg.point),
        .i_num     (r_point),
        .o_match   (point_m)
    );

    assign zone_ok = (r_zone == '0) || zone_m;

    always_comb begin
        case (cfg.ptype)
            TYPE_FULL:   n_match = zone_ok && net_m && node_m && point_m;
            TYPE_ZONE:   n_match = zone_m;
            TYPE_REGION: n_match = r_nl_open && r_region_known && zone_ok && net_m;
            TYPE_NET:    n_match = zone_ok && net_m;
            TYPE_HUB:    n_match = r_nl_open && r_hub_known && zone_ok && net_m && node_m;
            TYPE_NODE:   n_match = zone_ok && net_m && node_m;
            default:     n_match = 1'b0;
        endcase
    end

`ifndef SYNTHESIS
    a_out_from_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(r_in_valid))
        else $error("result appeared without a held item");

    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_in_valid && r_out_valid && i_stall))
        else $error("intake stalled with room in the pipeline");

    a_unused_type: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_adv && r_in_valid && (cfg.ptype > TYPE_NODE)) |=> !o_is_match)
        else $error("unused pattern type produced a match");
`endif

endmodule

// ===== src/mda_cfg_regs.sv =====
// Configuration registers of the 4D address matcher behind an APB-style port.
// Depends on mda_pkg for register indexes and the t_cfg struct.
module mda_cfg_regs (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [mda_pkg::ADDR_W-1:0]   paddr,
    input  logic [mda_pkg::DATA_W-1:0]   pwdata,
    output logic [mda_pkg::DATA_W-1:0]   prdata,
    output logic                         pready,
    output mda_pkg::t_cfg                o_cfg
);
    import mda_pkg::*;

    t_cfg       r_cfg;
    logic       wr_en;
    logic [2:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_idx = paddr[ADDR_W-1:3];
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (wr_en) begin
            case (reg_idx)
                REG_TYPE:  r_cfg.ptype <= pwdata[TYPE_W-1:0];
                REG_ZONE:  r_cfg.zone  <= pwdata[PAT_W-1:0];
                REG_NET:   r_cfg.net   <= pwdata[PAT_W-1:0];
                REG_NODE:  r_cfg.node  <= pwdata[PAT_W-1:0];
                REG_POINT: r_cfg.point <= pwdata[PAT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_TYPE:  prdata = DATA_W'(r_cfg.ptype);
            REG_ZONE:  prdata = DATA_W'(r_cfg.zone);
            REG_NET:   prdata = DATA_W'(r_cfg.net);
            REG_NODE:  prdata = DATA_W'(r_cfg.node);
            REG_POINT: prdata = DATA_W'(r_cfg.point);
            default:   prdata = '0;
        endcase
    end

endmodule

// ===== src/mda_comp_match.sv =====
// Matches one component pattern (digits, star, question mark) against the
// decimal text of a 16-bit number. Depends on mda_pkg for codes and num_to_dec.
module mda_comp_match #(
    parameter int PATTERN_CHARS = 9
) (
    input  logic [mda_pkg::PAT_W-1:0] i_pattern,
    input  logic [mda_pkg::NUM_W-1:0] i_num,
    output logic                      o_match
);
    import mda_pkg::*;

    localparam int EXT_W = CHAR_W * (PATTERN_CHARS + 1);
    localparam int PW    = (EXT_W > PAT_W) ? EXT_W : PAT_W;

    logic [PW-1:0]            pat_ext;
    t_dec                     dec;
    logic [CHAR_W-1:0]        raw_len;
    logic [CHAR_W-1:0]        len;
    logic [PATTERN_CHARS-1:0] is_star;
    logic [PATTERN_CHARS-1:0] pos_ok;

    // characters past the register width read as digit zero
    assign pat_ext = PW'(i_pattern);
    assign dec     = num_to_dec(i_num);
    assign raw_len = i_pattern[CHAR_W-1:0];
    assign len     = (raw_len > 4'(PATTERN_CHARS)) ? 4'(PATTERN_CHARS) : raw_len;

    for (genvar g = 0; g < PATTERN_CHARS; g++) begin : g_pos
        logic [CHAR_W-1:0] ch;
        assign ch         = pat_ext[CHAR_W*g+CHAR_W +: CHAR_W];
        assign is_star[g] = (ch == CODE_STAR);
        if (g < DIGITS) begin : g_dig
            assign pos_ok[g] = (3'(g) < dec.count) &&
                               ((ch == CODE_QUEST) ||
                                ((ch <= CODE_DIGIT_MAX) && (ch == dec.dig[g])));
        end else begin : g_none
            assign pos_ok[g] = 1'b0;
        end
    end

    always_comb begin
        logic done;
        done    = 1'b0;
        o_match = 1'b0;
        if (len == '0) begin
            o_match = 1'b1;
            done    = 1'b1;
        end
        for (int i = 0; i < PATTERN_CHARS; i++) begin
            if (!done && (4'(i) < len)) begin
                if (is_star[i]) begin
                    o_match = 1'b1;
                    done    = 1'b1;
                end else if (!pos_ok[i]) begin
                    o_match = 1'b0;
                    done    = 1'b1;
                end
            end
        end
        if (!done) begin
            o_match = (len == {1'b0, dec.count});
        end
    end

endmodule

// ===== test/tb_match_4d_address_pattern_top.sv =====
// Testbench for the 4D address pattern matcher: directed table, then random phases.
// Predicts each match result from its own copy of the patterns unless a table row fixes it; depends on mda_pkg.
module tb_match_4d_address_pattern_top;
    timeunit 1ns;
    timeprecision 1ps;

    import mda_pkg::*;

    localparam int PATTERN_CHARS   = 9;
    localparam int NUM_PHASES      = 16;
    localparam int ITEMS_PER_PHASE = 103;
    localparam int SETTLE_CYCLES   = 4;
    localparam int TAIL_CYCLES     = 8;
    localparam int WATCHDOG_LIMIT  = 5000;

    localparam logic [TYPE_W-1:0] TYPE_SPARE_LO = 3'd6;
    localparam logic [TYPE_W-1:0] TYPE_SPARE_HI = 3'd7;

    typedef enum logic [1:0] {ANS_CALC, ANS_NO, ANS_YES} answer_e;

    typedef struct packed {
        logic [TYPE_W-1:0] ptype;
        logic [PAT_W-1:0]  zone;
        logic [PAT_W-1:0]  net;
        logic [PAT_W-1:0]  node;
        logic [PAT_W-1:0]  point;
    } pattern_cfg_t;

    typedef struct packed {
        logic [NUM_W-1:0] zone;
        logic [NUM_W-1:0] net;
        logic [NUM_W-1:0] node;
        logic [NUM_W-1:0] point;
        logic             nl_open;
        logic             region_known;
        logic [NUM_W-1:0] region;
        logic             hub_known;
        logic [NUM_W-1:0] hub;
    } addr_item_t;

    typedef struct packed {
        pattern_cfg_t cfg;
        addr_item_t   item;
        answer_e      want;
    } stim_row_t;

    typedef struct packed {
        logic [2:0]                    count;
        logic [4:0][CHAR_W-1:0]        digit;
    } dec_text_t;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_stall;
    logic [NUM_W-1:0]   i_address_zone = '0;
    logic [NUM_W-1:0]   i_address_net = '0;
    logic [NUM_W-1:0]   i_address_node = '0;
    logic [NUM_W-1:0]   i_address_point = '0;
    logic               i_nodelist_open = 1'b0;
    logic               i_region_known = 1'b0;
    logic [NUM_W-1:0]   i_region_number = '0;
    logic               i_hub_known = 1'b0;
    logic [NUM_W-1:0]   i_hub_number = '0;
    logic               o_valid;
    logic               i_stall = 1'b0;
    logic               o_is_match;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [ADDR_W-1:0]  paddr = '0;
    logic [DATA_W-1:0]  pwdata = '0;
    logic [DATA_W-1:0]  prdata;
    logic               pready;

    answer_e            in_answer = ANS_CALC;
    pattern_cfg_t       cur_cfg = '0;
    logic               pending_match_q[$];
    stim_row_t          stim_rows[$];
    int                 n_errors = 0;
    int                 quiet_cycles = 0;
    int                 send_idle_pct = 0;
    int                 recv_stall_pct = 0;
    logic [NUM_W-1:0]   seed_zone;
    logic [NUM_W-1:0]   seed_net;
    logic [NUM_W-1:0]   seed_node;
    logic [NUM_W-1:0]   seed_point;

    match_4d_address_pattern_top #(
        .PATTERN_CHARS(PATTERN_CHARS)
    ) i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_address_zone (i_address_zone),
        .i_address_net  (i_address_net),
        .i_address_node (i_address_node),
        .i_address_point(i_address_point),
        .i_nodelist_open(i_nodelist_open),
        .i_region_known (i_region_known),
        .i_region_number(i_region_number),
        .i_hub_known    (i_hub_known),
        .i_hub_number   (i_hub_number),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_is_match     (o_is_match),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Decimal text, most significant digit in slot 0, no leading zeros.
    function automatic dec_text_t decimal_text(input logic [NUM_W-1:0] num);
        dec_text_t t;
        int        n;
        int        k;
        int        cnt;
        int        i;
        n   = int'(num);
        k   = n;
        cnt = 1;
        while (k >= 10) begin
            k = k / 10;
            cnt++;
        end
        t.digit = '0;
        for (i = cnt - 1; i >= 0; i--) begin
            t.digit[i] = 4'(n % 10);
            n = n / 10;
        end
        t.count = 3'(cnt);
        return t;
    endfunction

    function automatic logic component_matches(input logic [PAT_W-1:0] pat,
                                               input logic [NUM_W-1:0] num);
        dec_text_t         txt;
        int                len;
        int                i;
        logic [CHAR_W-1:0] ch;
        txt = decimal_text(num);
        len = int'(pat[3:0]);
        if (len > PATTERN_CHARS) len = PATTERN_CHARS;
        if (len == 0) return 1'b1;
        for (i = 0; i < len; i++) begin
            ch = (4 * i + 4 < PAT_W) ? pat[4 * i + 4 +: 4] : 4'd0;
            if (ch == CODE_STAR) return 1'b1;
            if (i >= int'(txt.count)) return 1'b0;
            if (ch == CODE_QUEST) continue;
            if (ch > CODE_DIGIT_MAX || ch != txt.digit[i]) return 1'b0;
        end
        return len == int'(txt.count);
    endfunction

    function automatic logic address_matches(input addr_item_t it, input pattern_cfg_t c);
        logic zone_ok;
        zone_ok = (it.zone == '0) || component_matches(c.zone, it.zone);
        case (c.ptype)
            TYPE_FULL: begin
                return zone_ok && component_matches(c.net, it.net) &&
                       component_matches(c.node, it.node) &&
                       component_matches(c.point, it.point);
            end
            TYPE_ZONE: begin
                return component_matches(c.zone, it.zone);
            end
            TYPE_REGION: begin
                return it.nl_open && it.region_known && zone_ok &&
                       component_matches(c.net, it.region);
            end
            TYPE_NET: begin
                return zone_ok && component_matches(c.net, it.net);
            end
            TYPE_HUB: begin
                return it.nl_open && it.hub_known && zone_ok &&
                       component_matches(c.net, it.net) &&
                       component_matches(c.node, it.hub);
            end
            TYPE_NODE: begin
                return zone_ok && component_matches(c.net, it.net) &&
                       component_matches(c.node, it.node);
            end
            default: begin
                return 1'b0;
            end
        endcase
    endfunction

    // Encode a pattern string: digits, '*', '?', and 'c'..'f' for reserved codes.
    function automatic logic [PAT_W-1:0] pattern_text(input string s);
        logic [PAT_W-1:0]  p;
        logic [7:0]        c;
        logic [CHAR_W-1:0] code;
        int                i;
        p      = '0;
        p[3:0] = 4'(s.len());
        for (i = 0; i < s.len(); i++) begin
            c = s[i];
            if (c == "*") code = CODE_STAR;
            else if (c == "?") code = CODE_QUEST;
            else if (c >= "0" && c <= "9") code = 4'(c - 8'd48);
            else code = 4'(c - 8'd87);
            p[4 * i + 4 +: 4] = code;
        end
        return p;
    endfunction

    // Start from the text of a seed, then mutate; junk fills the unused characters.
    function automatic logic [PAT_W-1:0] random_pattern(input logic [NUM_W-1:0] seed);
        dec_text_t        t;
        logic [PAT_W-1:0] p;
        int               len;
        int               i;
        int               r;
        t   = decimal_text(seed);
        p   = PAT_W'({$urandom(), $urandom()});
        len = int'(t.count);
        for (i = 0; i < int'(t.count); i++) begin
            r = $urandom_range(99);
            if (r < 65) p[4 * i + 4 +: 4] = t.digit[i];
            else if (r < 82) p[4 * i + 4 +: 4] = CODE_QUEST;
            else if (r < 90) p[4 * i + 4 +: 4] = CODE_STAR;
            else if (r < 96) p[4 * i + 4 +: 4] = 4'((int'(t.digit[i]) + 1) % 10);
            else p[4 * i + 4 +: 4] = 4'($urandom_range(12, 15));
        end
        r = $urandom_range(99);
        if (r < 8) len = 0;
        else if (r < 16) len = len + $urandom_range(1, 3);
        else if (r < 22 && len > 1) len = len - 1;
        else if (r < 26) len = $urandom_range(10, 15);
        p[3:0] = 4'(len);
        return p;
    endfunction

    function automatic logic [NUM_W-1:0] pick_seed();
        return NUM_W'($urandom_range(0, 65535) >> $urandom_range(0, 15));
    endfunction

    function automatic logic [NUM_W-1:0] near_value(input logic [NUM_W-1:0] seed);
        int r;
        r = $urandom_range(9);
        if (r < 6) return seed;
        else if (r == 6) return NUM_W'(seed + $urandom_range(1, 20));
        else if (r == 7) return pick_seed();
        else return NUM_W'($urandom());
    endfunction

    function automatic addr_item_t random_item();
        addr_item_t it;
        it.zone         = ($urandom_range(99) < 20) ? '0 : near_value(seed_zone);
        it.net          = near_value(seed_net);
        it.node         = near_value(seed_node);
        it.point        = near_value(seed_point);
        it.nl_open      = ($urandom_range(99) < 85);
        it.region_known = ($urandom_range(99) < 85);
        it.region       = near_value(seed_net);
        it.hub_known    = ($urandom_range(99) < 85);
        it.hub          = near_value(seed_node);
        return it;
    endfunction

    task automatic add_row(input logic [TYPE_W-1:0] ptype, input logic [PAT_W-1:0] zp,
                           input logic [PAT_W-1:0] np, input logic [PAT_W-1:0] dp,
                           input logic [PAT_W-1:0] pp, input logic [NUM_W-1:0] zone,
                           input logic [NUM_W-1:0] net, input logic [NUM_W-1:0] node,
                           input logic [NUM_W-1:0] point, input logic nl_open,
                           input logic region_known, input logic [NUM_W-1:0] region,
                           input logic hub_known, input logic [NUM_W-1:0] hub,
                           input answer_e want);
        stim_row_t row;
        row.cfg  = '{ptype, zp, np, dp, pp};
        row.item = '{zone, net, node, point, nl_open, region_known, region, hub_known, hub};
        row.want = want;
        stim_rows.push_back(row);
    endtask

    task automatic reg_write(input logic [2:0] idx, input logic [DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'({idx, 3'b000});
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
    endtask

    // Drop valid and hold until every predicted result has come back.
    task automatic drain_results();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_match_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic apply_config(input pattern_cfg_t c);
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        reg_write(REG_TYPE, DATA_W'(c.ptype));
        reg_write(REG_ZONE, DATA_W'(c.zone));
        reg_write(REG_NET, DATA_W'(c.net));
        reg_write(REG_NODE, DATA_W'(c.node));
        reg_write(REG_POINT, DATA_W'(c.point));
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        cur_cfg = c;
    endtask

    task automatic present_item(input addr_item_t it, input answer_e want);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid         <= 1'b1;
        i_address_zone  <= it.zone;
        i_address_net   <= it.net;
        i_address_node  <= it.node;
        i_address_point <= it.point;
        i_nodelist_open <= it.nl_open;
        i_region_known  <= it.region_known;
        i_region_number <= it.region;
        i_hub_known     <= it.hub_known;
        i_hub_number    <= it.hub;
        in_answer       <= want;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        i_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    always @(posedge i_clk) begin : result_check
        addr_item_t seen;
        logic       want_bit;
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                if (pending_match_q.size() == 0) begin
                    $error("unexpected result item: is_match=%0b", o_is_match);
                    n_errors++;
                end else begin
                    want_bit = pending_match_q.pop_front();
                    if (o_is_match !== want_bit) begin
                        $error("is_match: expected %0b, actual %0b", want_bit, o_is_match);
                        n_errors++;
                    end
                end
            end
            if (i_valid && !o_stall) begin
                seen = '{i_address_zone, i_address_net, i_address_node, i_address_point,
                         i_nodelist_open, i_region_known, i_region_number,
                         i_hub_known, i_hub_number};
                case (in_answer)
                    ANS_NO:  pending_match_q.push_back(1'b0);
                    ANS_YES: pending_match_q.push_back(1'b1);
                    default: pending_match_q.push_back(address_matches(seen, cur_cfg));
                endcase
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || (psel && penable))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        pattern_cfg_t cfg;
        stim_row_t    row;
        int           phase;
        int           n;

        // Full mode with empty patterns matches anything; unused types never match.
        add_row(TYPE_FULL, '0, '0, '0, '0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                1'b1, 1'b1, 16'hFFFF, 1'b1, 16'hFFFF, ANS_YES);
        add_row(TYPE_FULL, '0, '0, '0, '0, 0, 0, 0, 0, 1'b0, 1'b0, 0, 1'b0, 0, ANS_YES);
        add_row(TYPE_SPARE_HI, '0, '0, '0, '0, 1, 2, 3, 4, 1'b1, 1'b1, 5, 1'b1, 6, ANS_NO);
        add_row(TYPE_SPARE_LO, '0, '0, '0, '0, 1, 2, 3, 4, 1'b1, 1'b1, 5, 1'b1, 6, ANS_NO);
        // Zone mode does not skip a zero zone.
        add_row(TYPE_ZONE, pattern_text("2"), '0, '0, '0, 0, 1, 1, 1,
                1'b1, 1'b1, 1, 1'b1, 1, ANS_NO);
        add_row(TYPE_ZONE, pattern_text("2"), '0, '0, '0, 2, 1, 1, 1,
                1'b1, 1'b1, 1, 1'b1, 1, ANS_YES);
        add_row(TYPE_FULL, pattern_text("2"), pattern_text("5020"), pattern_text("1??"),
                pattern_text("*"), 2, 5020, 100, 0, 1'b0, 1'b0, 0, 1'b0, 0, ANS_CALC);
        add_row(TYPE_FULL, pattern_text("2"), pattern_text("5020"), pattern_text("1??"),
                pattern_text("*"), 0, 5020, 199, 7, 1'b0, 1'b0, 0, 1'b0, 0, ANS_CALC);
        add_row(TYPE_FULL, pattern_text("2"), pattern_text("5020"), pattern_text("1??"),
                pattern_text("*"), 3, 5020, 100, 0, 1'b0, 1'b0, 0, 1'b0, 0, ANS_CALC);
        add_row(TYPE_FULL, pattern_text("2"), pattern_text("5020"), pattern_text("1??"),
                pattern_text("*"), 2, 50200, 100, 0, 1'b0, 1'b0, 0, 1'b0, 0, ANS_CALC);
        add_row(TYPE_NET, pattern_text("2"), pattern_text("50200"), '0, '0, 2, 5020, 0, 0,
                1'b0, 1'b0, 0, 1'b0, 0, ANS_CALC);
        // Region and hub need an open nodelist and a found lookup.
        add_row(TYPE_REGION, pattern_text("2"), pattern_text("25"), '0, '0, 2, 1, 1, 1,
                1'b0, 1'b1, 25, 1'b1, 1, ANS_NO);
        add_row(TYPE_REGION, pattern_text("2"), pattern_text("25"), '0, '0, 2, 1, 1, 1,
                1'b1, 1'b0, 25, 1'b1, 1, ANS_NO);
        add_row(TYPE_REGION, pattern_text("2"), pattern_text("25"), '0, '0, 2, 1, 1, 1,
                1'b1, 1'b1, 25, 1'b0, 1, ANS_CALC);
        add_row(TYPE_HUB, pattern_text("2"), pattern_text("5020"), pattern_text("1??"), '0,
                2, 5020, 7, 0, 1'b1, 1'b1, 0, 1'b0, 101, ANS_NO);
        add_row(TYPE_HUB, pattern_text("2"), pattern_text("5020"), pattern_text("1??"), '0,
                2, 5020, 7, 0, 1'b1, 1'b0, 0, 1'b1, 101, ANS_CALC);
        add_row(TYPE_NET, '0, pattern_text("5*"), '0, '0, 9, 5, 0, 0,
                1'b0, 1'b0, 0, 1'b0, 0, ANS_CALC);
        add_row(TYPE_NODE, '0, '0, pattern_text("?"), '0, 0, 0, 65535, 0,
                1'b0, 1'b0, 0, 1'b0, 0, ANS_CALC);
        add_row(TYPE_NODE, '0, '0, pattern_text("?????"), '0, 0, 0, 65535, 0,
                1'b0, 1'b0, 0, 1'b0, 0, ANS_CALC);
        // Reserved codes fail their position unless a star comes first.
        add_row(TYPE_NET, '0, pattern_text("c"), '0, '0, 0, 7, 0, 0,
                1'b0, 1'b0, 0, 1'b0, 0, ANS_NO);
        add_row(TYPE_NET, '0, pattern_text("*c"), '0, '0, 0, 7, 0, 0,
                1'b0, 1'b0, 0, 1'b0, 0, ANS_CALC);
        add_row(TYPE_NET, '0, pattern_text("50d"), '0, '0, 0, 502, 0, 0,
                1'b0, 1'b0, 0, 1'b0, 0, ANS_CALC);
        // Length field above the character count saturates.
        add_row(TYPE_NET, '0, 40'h00_0000_00AF, '0, '0, 0, 12345, 0, 0,
                1'b0, 1'b0, 0, 1'b0, 0, ANS_CALC);
        add_row(TYPE_NET, '0, 40'h98_7654_321F, '0, '0, 0, 12345, 0, 0,
                1'b0, 1'b0, 0, 1'b0, 0, ANS_CALC);
        add_row(TYPE_FULL, pattern_text("65535"), pattern_text("65535"),
                pattern_text("65535"), pattern_text("65535"), 65535, 65535, 65535, 65535,
                1'b0, 1'b0, 0, 1'b0, 0, ANS_CALC);

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (stim_rows[k]) begin
            row = stim_rows[k];
            if (row.cfg != cur_cfg) apply_config(row.cfg);
            present_item(row.item, row.want);
        end

        for (phase = 0; phase < NUM_PHASES; phase++) begin
            case (phase % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 80; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 80; end
                default: begin send_idle_pct = 13; recv_stall_pct = 13; end
            endcase
            seed_zone  = ($urandom_range(1) != 0) ? NUM_W'($urandom_range(1, 9)) : pick_seed();
            seed_net   = pick_seed();
            seed_node  = pick_seed();
            seed_point = pick_seed();
            cfg.zone   = random_pattern(seed_zone);
            cfg.net    = random_pattern(seed_net);
            cfg.node   = random_pattern(seed_node);
            cfg.point  = random_pattern(seed_point);
            case (phase)
                0: begin
                    cfg = '0;
                end
                1: begin
                    cfg.ptype = TYPE_NODE;
                    cfg.zone  = pattern_text("?????");
                    cfg.net   = pattern_text("?????");
                    cfg.node  = pattern_text("?????");
                end
                2: begin
                    cfg.ptype = TYPE_SPARE_HI;
                end
                3: begin
                    cfg.ptype = TYPE_FULL;
                    cfg.zone[3:0]  = 4'hF;
                    cfg.net[3:0]   = 4'hF;
                    cfg.node[3:0]  = 4'hF;
                    cfg.point[3:0] = 4'hF;
                end
                default: begin
                    cfg.ptype = TYPE_W'((phase - 4) % 6);
                end
            endcase
            apply_config(cfg);
            for (n = 0; n < ITEMS_PER_PHASE; n++) begin
                if (n == ITEMS_PER_PHASE / 2 && phase % 5 == 2) drain_results();
                present_item(random_item(), ANS_CALC);
            end
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (n_errors == 0 && pending_match_q.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// ===== match_4d_address_pattern_top.f =====
src/mda_pkg.sv
src/mda_cfg_regs.sv
src/mda_comp_match.sv
src/match_4d_address_pattern_top.sv
test/tb_match_4d_address_pattern_top.sv
